[rtl/gbps_pkg.sv]
// ----------------------------------------------------------------------------
// gbps_pkg
// Types and constants shared by the boot partition selector files.
// ----------------------------------------------------------------------------
package gbps_pkg;

  localparam int unsigned LbaW   = 64;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned CfgIdW = 3;
  localparam int unsigned MaxCap = 128;

  // "EFI PART" as a little-endian 64-bit word
  localparam logic [LbaW-1:0] EfiSignature = 64'h5452_4150_2049_4645;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_ENTRY = 2'd1,
    OP_END   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [CfgIdW-1:0] {
    CFG_LBA_LIMIT    = 3'd0,
    CFG_WANT_TYPE_LO = 3'd1,
    CFG_WANT_TYPE_HI = 3'd2,
    CFG_WANT_UNIQ_LO = 3'd3,
    CFG_WANT_UNIQ_HI = 3'd4,
    CFG_TYPE_MATCH   = 3'd5,
    CFG_UNIQ_MATCH   = 3'd6,
    CFG_UNUSED       = 3'd7
  } cfg_id_e;

endpackage

[rtl/gbps_if.sv]
// ----------------------------------------------------------------------------
// gbps_if
// Request channels of the boot partition selector: entry input, result
// output and register write.
// ----------------------------------------------------------------------------
interface gbps_in_if import gbps_pkg::*; ();
  logic            valid;
  logic            ready;
  op_e             op;
  logic [LbaW-1:0] signature_word;
  logic [LbaW-1:0] entry_first_lba;
  logic [LbaW-1:0] entry_last_lba;
  logic [LbaW-1:0] entry_type_lo;
  logic [LbaW-1:0] entry_type_hi;
  logic [LbaW-1:0] entry_uniq_lo;
  logic [LbaW-1:0] entry_uniq_hi;

  modport source (
    output valid, op, signature_word, entry_first_lba, entry_last_lba,
           entry_type_lo, entry_type_hi, entry_uniq_lo, entry_uniq_hi,
    input  ready
  );
  modport sink (
    input  valid, op, signature_word, entry_first_lba, entry_last_lba,
           entry_type_lo, entry_type_hi, entry_uniq_lo, entry_uniq_hi,
    output ready
  );
endinterface

interface gbps_out_if import gbps_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IdxW-1:0] chosen_index;
  logic [LbaW-1:0]        chosen_first_lba;
  logic [LbaW-1:0]        chosen_last_lba;
  logic                   table_valid;
  logic                   index_overflow;

  modport source (
    output valid, chosen_index, chosen_first_lba, chosen_last_lba,
           table_valid, index_overflow,
    input  ready
  );
  modport sink (
    input  valid, chosen_index, chosen_first_lba, chosen_last_lba,
           table_valid, index_overflow,
    output ready
  );
endinterface

interface gbps_cfg_if import gbps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CfgIdW-1:0] index;
  logic [LbaW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/gpt_boot_partition_select_top.sv]
// ----------------------------------------------------------------------------
// gpt_boot_partition_select_top
// Picks the boot partition from a stream of partition table entries.
// ----------------------------------------------------------------------------
// throughput: one request per cycle on the input, end requests included, while the
//   result register has room; an end request shows its result through the input
//   register, then the result register; start and entry requests give none
// an end request waits in the input register while the result register is full
// reset: control and table state reset asynchronously (held index to all ones),
//   limit register back to one, match targets and enables cleared
module gpt_boot_partition_select_top import gbps_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  gbps_cfg_if.sink     cfg_i,
  gbps_in_if.sink      in_i,
  gbps_out_if.source   out_o
);

  // entries beyond the index range of chosen_index are never taken
  localparam int unsigned Cap  = (MAX_ENTRIES > MaxCap) ? MaxCap : MAX_ENTRIES;
  localparam int unsigned CntW = $clog2(Cap + 1);

  // --------------------------------------------------------------------------
  // configuration registers, not guarded: the user's writes must only arrive while the block is idle
  // --------------------------------------------------------------------------
  logic [LbaW-1:0] lba_limit_q;
  logic [LbaW-1:0] lim_m1_q;      // limit minus one, kept ready for the clip
  logic [LbaW-1:0] want_type_lo_q, want_type_hi_q;
  logic [LbaW-1:0] want_uniq_lo_q, want_uniq_hi_q;
  logic            type_match_on_q, uniq_match_on_q;
  cfg_id_e         cfg_id;

  assign cfg_i.ready = 1'b1;
  assign cfg_id      = cfg_id_e'(cfg_i.index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lba_limit_q     <= LbaW'(1);
      lim_m1_q        <= '0;
      want_type_lo_q  <= '0;
      want_type_hi_q  <= '0;
      want_uniq_lo_q  <= '0;
      want_uniq_hi_q  <= '0;
      type_match_on_q <= 1'b0;
      uniq_match_on_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_id)
        CFG_LBA_LIMIT: begin
          lba_limit_q <= cfg_i.data;
          lim_m1_q    <= cfg_i.data - LbaW'(1);
        end
        CFG_WANT_TYPE_LO: want_type_lo_q  <= cfg_i.data;
        CFG_WANT_TYPE_HI: want_type_hi_q  <= cfg_i.data;
        CFG_WANT_UNIQ_LO: want_uniq_lo_q  <= cfg_i.data;
        CFG_WANT_UNIQ_HI: want_uniq_hi_q  <= cfg_i.data;
        CFG_TYPE_MATCH:   type_match_on_q <= cfg_i.data[0];
        CFG_UNIQ_MATCH:   uniq_match_on_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  logic            s1_valid_q;
  op_e             s1_op_q;
  logic [LbaW-1:0] s1_sig_q, s1_first_q, s1_last_q;
  logic [LbaW-1:0] s1_type_lo_q, s1_type_hi_q, s1_uniq_lo_q, s1_uniq_hi_q;
  logic            s1_fire, out_free, in_take;

  // an end request may only move on when the result register has room
  assign out_free   = !out_o.valid || out_o.ready;
  assign s1_fire    = s1_valid_q && ((s1_op_q != OP_END) || out_free);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_op_q      <= in_i.op;
      s1_sig_q     <= in_i.signature_word;
      s1_first_q   <= in_i.entry_first_lba;
      s1_last_q    <= in_i.entry_last_lba;
      s1_type_lo_q <= in_i.entry_type_lo;
      s1_type_hi_q <= in_i.entry_type_hi;
      s1_uniq_lo_q <= in_i.entry_uniq_lo;
      s1_uniq_hi_q <= in_i.entry_uniq_hi;
    end
  end

  // --------------------------------------------------------------------------
  // table state and the per-entry decision
  // --------------------------------------------------------------------------
  logic            sig_good_q, sig_good_d;
  logic            match_done_q, match_done_d;
  logic [CntW-1:0] entry_count_q, entry_count_d;
  logic            overflow_q, overflow_d;
  logic [IdxW-1:0] hold_index_q, hold_index_d;
  logic [LbaW-1:0] hold_first_q, hold_first_d;
  logic [LbaW-1:0] hold_last_q, hold_last_d;

  logic            span_ok, type_hit, uniq_hit, hit, full;
  logic [LbaW:0]   bound_sum;
  logic [LbaW-1:0] bound, clip_last;

  // span check: unsigned wrapping difference below the limit
  assign span_ok  = (s1_last_q - s1_first_q) < lba_limit_q;
  assign type_hit = type_match_on_q && (s1_type_lo_q == want_type_lo_q)
                                    && (s1_type_hi_q == want_type_hi_q);
  assign uniq_hit = uniq_match_on_q && (s1_uniq_lo_q == want_uniq_lo_q)
                                    && (s1_uniq_hi_q == want_uniq_hi_q);
  assign hit      = span_ok && (type_hit || uniq_hit);
  assign full     = entry_count_q >= CntW'(Cap);

  // clip bound for the first entry, saturating at all ones
  assign bound_sum = {1'b0, s1_first_q} + {1'b0, lim_m1_q};
  assign bound     = bound_sum[LbaW] ? '1 : bound_sum[LbaW-1:0];
  assign clip_last = (s1_last_q < bound) ? s1_last_q : bound;

  always_comb begin
    sig_good_d    = sig_good_q;
    match_done_d  = match_done_q;
    entry_count_d = entry_count_q;
    overflow_d    = overflow_q;
    hold_index_d  = hold_index_q;
    hold_first_d  = hold_first_q;
    hold_last_d   = hold_last_q;
    if (s1_fire) begin
      case (s1_op_q)
        OP_START: begin
          sig_good_d    = (s1_sig_q == EfiSignature);
          match_done_d  = 1'b0;
          entry_count_d = '0;
          overflow_d    = 1'b0;
          hold_index_d  = '1;
          hold_first_d  = '0;
          hold_last_d   = '0;
        end
        OP_ENTRY: begin
          if (full) begin
            overflow_d = 1'b1;
          end else begin
            entry_count_d = entry_count_q + CntW'(1);
            if (!match_done_q) begin
              // first entry seeds the fallback range
              if (entry_count_q == '0) begin
                hold_first_d = s1_first_q;
                hold_last_d  = clip_last;
              end
              if (hit) begin
                match_done_d = 1'b1;
                hold_index_d = IdxW'(entry_count_q);
                hold_first_d = s1_first_q;
                hold_last_d  = s1_last_q;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_good_q    <= 1'b0;
      match_done_q  <= 1'b0;
      entry_count_q <= '0;
      overflow_q    <= 1'b0;
      hold_index_q  <= '1;
      hold_first_q  <= '0;
      hold_last_q   <= '0;
    end else begin
      sig_good_q    <= sig_good_d;
      match_done_q  <= match_done_d;
      entry_count_q <= entry_count_d;
      overflow_q    <= overflow_d;
      hold_index_q  <= hold_index_d;
      hold_first_q  <= hold_first_d;
      hold_last_q   <= hold_last_d;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  logic            out_valid_q, end_fire, use_raw;
  logic [IdxW-1:0] out_index_q;
  logic [LbaW-1:0] out_first_q, out_last_q;
  logic            out_tvalid_q, out_ovf_q;

  assign end_fire = s1_fire && (s1_op_q == OP_END);
  // bad signature or empty table falls back to the raw range
  assign use_raw  = !sig_good_q || (entry_count_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (end_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_fire) begin
      out_index_q  <= use_raw ? '1 : hold_index_q;
      out_first_q  <= use_raw ? '0 : hold_first_q;
      out_last_q   <= use_raw ? lim_m1_q : hold_last_q;
      out_tvalid_q <= sig_good_q;
      out_ovf_q    <= overflow_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.chosen_index     = signed'(out_index_q);
  assign out_o.chosen_first_lba = out_first_q;
  assign out_o.chosen_last_lba  = out_last_q;
  assign out_o.table_valid      = out_tvalid_q;
  assign out_o.index_overflow   = out_ovf_q;

endmodule

[rtl/gbps_checker.sv]
// ----------------------------------------------------------------------------
// gbps_checker
// Port-level checks on the result channel of the boot partition selector.
// ----------------------------------------------------------------------------
module gbps_checker import gbps_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic signed [IdxW-1:0] chosen_index_i,
  input logic [LbaW-1:0]        chosen_first_lba_i,
  input logic                   table_valid_i
);

  // a chosen entry is only reported for a good table
  a_pick_needs_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (chosen_index_i != -8'sd1) |-> table_valid_i)
    else $error("entry chosen with bad signature");

  // negative index only as the no-match code
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && chosen_index_i[IdxW-1] |-> (chosen_index_i == -8'sd1))
    else $error("chosen index out of range");

  // bad table gives the raw range starting at block zero
  a_raw_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !table_valid_i |-> (chosen_first_lba_i == '0))
    else $error("raw range does not start at zero");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(chosen_index_i)
                                   && $stable(chosen_first_lba_i))
    else $error("stalled result changed");

endmodule

bind gpt_boot_partition_select_top gbps_checker u_gbps_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .chosen_index_i     (out_o.chosen_index),
  .chosen_first_lba_i (out_o.chosen_first_lba),
  .table_valid_i      (out_o.table_valid)
);

[bench/tb_gpt_boot_partition_select_top.sv]
// ----------------------------------------------------------------------------
// tb_gpt_boot_partition_select_top
// Self-checking bench for the boot partition selector. A queue of requests
// and register writes feeds a clocked driver, a shadow of the selection logic
// predicts each end-of-table choice, and a clocked monitor compares every
// result field against the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_gpt_boot_partition_select_top;
  import gbps_pkg::*;

  localparam int unsigned MaxEntries   = 128;
  localparam int unsigned Capacity     = (MaxEntries > MaxCap) ? MaxCap : MaxEntries;
  // random part of the plan, oversized table included; directed cases add the rest
  localparam int          RandRequests = 420;
  localparam int          NumPhases    = 6;
  // idle wait before a register write or a pause ends, past the input and result registers
  localparam int          SettleCycles = 4;
  localparam int          DrainCycles  = 10;
  localparam int          TimeoutTime  = 5_000_000;

  typedef enum logic [1:0] {
    ACT_REQ,
    ACT_CFG,
    ACT_DRAIN
  } act_kind_e;

  // one pending step of stimulus: a request, a register write or a pause
  typedef struct {
    act_kind_e       kind;
    op_e             op;
    logic [LbaW-1:0] sig;
    logic [LbaW-1:0] first_lba;
    logic [LbaW-1:0] last_lba;
    logic [LbaW-1:0] type_lo;
    logic [LbaW-1:0] type_hi;
    logic [LbaW-1:0] uniq_lo;
    logic [LbaW-1:0] uniq_hi;
    cfg_id_e         reg_id;
    logic [LbaW-1:0] reg_data;
  } sel_action_t;

  // one predicted end-of-table choice
  typedef struct {
    logic signed [IdxW-1:0] idx;
    logic [LbaW-1:0]        first_lba;
    logic [LbaW-1:0]        last_lba;
    logic                   tbl_valid;
    logic                   ovf;
  } boot_choice_t;

  logic clk_i;
  logic rst_ni;

  gbps_cfg_if cfg_ch ();
  gbps_in_if  in_ch ();
  gbps_out_if out_ch ();

  gpt_boot_partition_select_top #(
    .MAX_ENTRIES(MaxEntries)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // stimulus and expectations
  sel_action_t  action_q[$];
  boot_choice_t pending_choices[$];

  // register shadow used by the predictor, updated on accepted writes
  logic [LbaW-1:0] reg_limit;
  logic [LbaW-1:0] reg_type_lo;
  logic [LbaW-1:0] reg_type_hi;
  logic [LbaW-1:0] reg_uniq_lo;
  logic [LbaW-1:0] reg_uniq_hi;
  logic            reg_type_on;
  logic            reg_uniq_on;

  // table state of the predictor
  logic                   tbl_sig_ok;
  logic                   tbl_locked;
  int unsigned            tbl_count;
  logic                   tbl_ovf;
  logic signed [IdxW-1:0] tbl_idx;
  logic [LbaW-1:0]        tbl_first;
  logic [LbaW-1:0]        tbl_last;

  // register values as the generator sees them, ahead of the driver
  logic [LbaW-1:0] gen_limit;
  logic [LbaW-1:0] gen_type_lo;
  logic [LbaW-1:0] gen_type_hi;
  logic [LbaW-1:0] gen_uniq_lo;
  logic [LbaW-1:0] gen_uniq_hi;
  int              gen_req_count;
  int              gen_tables;

  // driver bookkeeping
  sel_action_t in_cur;
  sel_action_t cfg_cur;
  bit          in_busy;
  bit          cfg_busy;
  bit          in_lazy;
  int          gap_left;
  int          settle;
  bit          stim_done;
  logic        nx_in_vld;
  logic        nx_cfg_vld;
  bit          took_in;

  // monitor bookkeeping
  bit   out_lazy;
  int   rdy_wait;
  logic nx_rdy;

  int mismatches;
  int results_seen;
  int chosen_seen;
  int ovf_seen;
  int cfg_writes;

  function automatic logic [LbaW-1:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  task automatic apply_reg(input cfg_id_e id, input logic [LbaW-1:0] d);
    case (id)
      CFG_LBA_LIMIT:    reg_limit   = d;
      CFG_WANT_TYPE_LO: reg_type_lo = d;
      CFG_WANT_TYPE_HI: reg_type_hi = d;
      CFG_WANT_UNIQ_LO: reg_uniq_lo = d;
      CFG_WANT_UNIQ_HI: reg_uniq_hi = d;
      CFG_TYPE_MATCH:   reg_type_on = d[0];
      CFG_UNIQ_MATCH:   reg_uniq_on = d[0];
      default: ;
    endcase
  endtask

  task automatic boot_choice_step(input sel_action_t a);
    boot_choice_t    c;
    logic [LbaW-1:0] bound;
    logic            hit;
    int unsigned     idx;
    case (a.op)
      OP_START: begin
        tbl_sig_ok = (a.sig == EfiSignature);
        tbl_locked = 1'b0;
        tbl_count  = 0;
        tbl_ovf    = 1'b0;
        tbl_idx    = '1;
        tbl_first  = '0;
        tbl_last   = '0;
      end
      OP_ENTRY: begin
        if (tbl_count >= Capacity) begin
          tbl_ovf = 1'b1;
        end else begin
          idx = tbl_count;
          tbl_count++;
          if (!tbl_locked) begin
            // the first entry is the fallback, clipped to the limit
            if (idx == 0) begin
              bound = a.first_lba + (reg_limit - 64'd1);
              if (bound < a.first_lba) bound = '1;
              tbl_first = a.first_lba;
              tbl_last  = (a.last_lba < bound) ? a.last_lba : bound;
            end
            if (a.last_lba - a.first_lba < reg_limit) begin
              hit = (reg_type_on && a.type_lo == reg_type_lo && a.type_hi == reg_type_hi) ||
                    (reg_uniq_on && a.uniq_lo == reg_uniq_lo && a.uniq_hi == reg_uniq_hi);
              if (hit) begin
                tbl_locked = 1'b1;
                tbl_idx    = idx[IdxW-1:0];
                tbl_first  = a.first_lba;
                tbl_last   = a.last_lba;
              end
            end
          end
        end
      end
      OP_END: begin
        if (!tbl_sig_ok || tbl_count == 0) begin
          c.idx       = '1;
          c.first_lba = '0;
          c.last_lba  = reg_limit - 64'd1;
        end else begin
          c.idx       = tbl_idx;
          c.first_lba = tbl_first;
          c.last_lba  = tbl_last;
        end
        c.tbl_valid = tbl_sig_ok;
        c.ovf       = tbl_ovf;
        pending_choices.push_back(c);
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // stimulus builders
  // --------------------------------------------------------------------------

  task automatic push_req(input op_e op, input logic [LbaW-1:0] sig, first_lba, last_lba,
                          type_lo, type_hi, uniq_lo, uniq_hi);
    sel_action_t a;
    a.kind      = ACT_REQ;
    a.op        = op;
    a.sig       = sig;
    a.first_lba = first_lba;
    a.last_lba  = last_lba;
    a.type_lo   = type_lo;
    a.type_hi   = type_hi;
    a.uniq_lo   = uniq_lo;
    a.uniq_hi   = uniq_hi;
    a.reg_id    = CFG_UNUSED;
    a.reg_data  = '0;
    action_q.push_back(a);
    if (op != OP_NONE) gen_req_count++;
    if (op == OP_END) gen_tables++;
  endtask

  // request whose unused fields carry noise
  task automatic push_bare(input op_e op, input logic [LbaW-1:0] sig);
    push_req(op, sig, rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
  endtask

  task automatic push_cfg(input cfg_id_e id, input logic [LbaW-1:0] d);
    sel_action_t a;
    a = '{kind: ACT_CFG, op: OP_NONE, reg_id: id, reg_data: d, default: '0};
    action_q.push_back(a);
    case (id)
      CFG_LBA_LIMIT:    gen_limit   = d;
      CFG_WANT_TYPE_LO: gen_type_lo = d;
      CFG_WANT_TYPE_HI: gen_type_hi = d;
      CFG_WANT_UNIQ_LO: gen_uniq_lo = d;
      CFG_WANT_UNIQ_HI: gen_uniq_hi = d;
      default: ;
    endcase
  endtask

  task automatic push_drain();
    sel_action_t a;
    a = '{kind: ACT_DRAIN, op: OP_NONE, reg_id: CFG_UNUSED, default: '0};
    action_q.push_back(a);
  endtask

  task automatic push_setting(input logic [LbaW-1:0] lim, tlo, thi, ulo, uhi,
                              input logic t_on, u_on);
    push_cfg(CFG_LBA_LIMIT, lim);
    push_cfg(CFG_WANT_TYPE_LO, tlo);
    push_cfg(CFG_WANT_TYPE_HI, thi);
    push_cfg(CFG_WANT_UNIQ_LO, ulo);
    push_cfg(CFG_WANT_UNIQ_HI, uhi);
    // upper bits of the enables are noise
    push_cfg(CFG_TYPE_MATCH, (rnd64() & ~64'd1) | {63'd0, t_on});
    push_cfg(CFG_UNIQ_MATCH, (rnd64() & ~64'd1) | {63'd0, u_on});
  endtask

  // identifier that hits the target, misses it by one bit or is random; random when plain
  task automatic pick_id(input logic [LbaW-1:0] lo_t, hi_t, input bit plain,
                         output logic [LbaW-1:0] lo, hi);
    lo = rnd64();
    hi = rnd64();
    if (!plain) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          lo = lo_t;
          hi = hi_t;
        end
        2: begin
          lo = lo_t ^ (64'd1 << $urandom_range(0, 63));
          hi = hi_t;
        end
        3: begin
          lo = lo_t;
          hi = hi_t ^ (64'd1 << $urandom_range(0, 63));
        end
        default: ;
      endcase
    end
  endtask

  task automatic gen_entry(input bit plain);
    logic [LbaW-1:0] first_lba, span, tlo, thi, ulo, uhi;
    case ($urandom_range(0, 6))
      0:       first_lba = '1 - 64'($urandom_range(0, 20));
      1:       first_lba = 64'($urandom_range(0, 20));
      default: first_lba = rnd64();
    endcase
    // spans straddle the limit on both sides
    case ($urandom_range(0, 3))
      0:       span = rnd64();
      1:       span = gen_limit - 64'd1;
      2:       span = gen_limit;
      default: span = 64'($urandom_range(0, 20));
    endcase
    pick_id(gen_type_lo, gen_type_hi, plain, tlo, thi);
    pick_id(gen_uniq_lo, gen_uniq_hi, plain, ulo, uhi);
    push_req(OP_ENTRY, rnd64(), first_lba, first_lba + span, tlo, thi, ulo, uhi);
  endtask

  function automatic logic [LbaW-1:0] pick_sig();
    if ($urandom_range(0, 9) != 0) return EfiSignature;
    if ($urandom_range(0, 1) != 0) return rnd64();
    return EfiSignature ^ (64'd1 << $urandom_range(0, 63));
  endfunction

  // well-formed table with random content, sometimes extended after its end or ended twice
  task automatic gen_table();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
    push_bare(OP_START, pick_sig());
    repeat (n) gen_entry(1'b0);
    push_bare(OP_END, rnd64());
    case ($urandom_range(0, 9))
      0: begin
        repeat ($urandom_range(1, 3)) gen_entry(1'b0);
        push_bare(OP_END, rnd64());
      end
      1: push_bare(OP_END, rnd64());
      default: ;
    endcase
  endtask

  // table past capacity, with a hit on the last slot that still counts
  task automatic gen_big_table();
    int n;
    logic [LbaW-1:0] first_lba;
    n = Capacity + $urandom_range(1, 6);
    push_bare(OP_START, EfiSignature);
    for (int i = 0; i < n; i++) begin
      if (i == Capacity - 1) begin
        first_lba = rnd64();
        push_req(OP_ENTRY, rnd64(), first_lba, first_lba, gen_type_lo, gen_type_hi,
                 rnd64(), rnd64());
      end else begin
        gen_entry(1'b1);
      end
    end
    push_bare(OP_END, rnd64());
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 4)) push_bare(op_e'(2'($urandom_range(0, 3))), rnd64());
  endtask

  // --------------------------------------------------------------------------
  // clock and reset
  // --------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni       = 1'b0;
    // every block input known from time zero
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_NONE;
    in_ch.signature_word  = '0;
    in_ch.entry_first_lba = '0;
    in_ch.entry_last_lba  = '0;
    in_ch.entry_type_lo   = '0;
    in_ch.entry_type_hi   = '0;
    in_ch.entry_uniq_lo   = '0;
    in_ch.entry_uniq_hi   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // stimulus plan
  // --------------------------------------------------------------------------

  initial begin : build_plan
    logic [LbaW-1:0] tlo, thi, ulo, uhi;
    logic [LbaW-1:0] lim;
    logic            t_on, u_on;
    int              goal, mid;
    bit              paused;
    bit              big_done;

    gen_limit     = 64'd1;
    gen_type_lo   = '0;
    gen_type_hi   = '0;
    gen_uniq_lo   = '0;
    gen_uniq_hi   = '0;
    gen_req_count = 0;
    gen_tables    = 0;
    tlo = rnd64();
    thi = rnd64();
    ulo = rnd64();
    uhi = rnd64();

    // end right after reset, no start seen, limit of one
    push_bare(OP_END, rnd64());
    // entry with no start still reports the raw range
    push_req(OP_ENTRY, rnd64(), 64'd7, 64'd7, rnd64(), rnd64(), rnd64(), rnd64());
    push_bare(OP_END, rnd64());
    // unused op code is dropped
    push_bare(OP_NONE, rnd64());

    push_setting(64'd16, tlo, thi, ulo, uhi, 1'b1, 1'b1);
    push_cfg(CFG_UNUSED, rnd64());
    // type hit on a span too long, then a unique id hit on index one
    push_bare(OP_START, EfiSignature);
    push_req(OP_ENTRY, rnd64(), 64'd100, 64'd200, tlo, thi, rnd64(), rnd64());
    push_req(OP_ENTRY, rnd64(), 64'd5, 64'd10, rnd64(), rnd64(), ulo, uhi);
    push_bare(OP_END, rnd64());
    // repeated end, then entries after an end join the same table
    push_bare(OP_END, rnd64());
    push_req(OP_ENTRY, rnd64(), 64'd0, 64'd0, tlo, thi, ulo, uhi);
    push_bare(OP_END, rnd64());
    // signature one bit off
    push_bare(OP_START, EfiSignature ^ 64'd1);
    push_req(OP_ENTRY, rnd64(), 64'd1, 64'd2, tlo, thi, ulo, uhi);
    push_bare(OP_END, rnd64());
    // good signature with no entries
    push_bare(OP_START, EfiSignature);
    push_bare(OP_END, rnd64());
    // clip bound runs past all ones and saturates
    push_bare(OP_START, EfiSignature);
    push_req(OP_ENTRY, rnd64(), '1 - 64'd3, '1, rnd64(), rnd64(), rnd64(), rnd64());
    push_bare(OP_END, rnd64());

    // limit of zero: nothing chosen, fallback unclipped, raw range all ones
    push_cfg(CFG_LBA_LIMIT, '0);
    push_bare(OP_START, EfiSignature);
    push_req(OP_ENTRY, rnd64(), '0, '1, tlo, thi, ulo, uhi);
    push_bare(OP_END, rnd64());
    push_bare(OP_START, EfiSignature);
    push_bare(OP_END, rnd64());

    // random phases, one register setting each
    big_done = 1'b0;
    for (int ph = 0; ph < NumPhases; ph++) begin
      tlo = rnd64();
      thi = rnd64();
      ulo = rnd64();
      uhi = rnd64();
      case (ph)
        0: begin
          lim = 64'd1;
          tlo = '0; thi = '0; ulo = '0; uhi = '0;
          t_on = 1'b1; u_on = 1'b0;
        end
        1: begin
          lim = '1;
          tlo = '1; thi = '1; ulo = '1; uhi = '1;
          t_on = 1'b0; u_on = 1'b1;
        end
        2: begin
          lim = 64'd16;
          t_on = 1'b1; u_on = 1'b1;
        end
        3: begin
          lim = '0;
          t_on = 1'b1; u_on = 1'b1;
        end
        4: begin
          lim = 64'($urandom_range(1, 64));
          t_on = 1'b0; u_on = 1'b0;
        end
        default: begin
          lim = rnd64();
          t_on = 1'b1; u_on = 1'b1;
        end
      endcase
      push_setting(lim, tlo, thi, ulo, uhi, t_on, u_on);
      if (ph == 4) push_cfg(CFG_UNUSED, rnd64());

      goal   = gen_req_count + RandRequests / NumPhases;
      mid    = gen_req_count + RandRequests / (2 * NumPhases);
      paused = 1'b0;
      while (gen_req_count < goal) begin
        if (ph == 2 && !big_done) begin
          gen_big_table();
          big_done = 1'b1;
        end else if ($urandom_range(0, 99) < 85) begin
          gen_table();
        end else begin
          gen_noise();
        end
        // hold the sender until every choice is back
        if (!paused && gen_req_count >= mid) begin
          push_drain();
          paused = 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // driver: requests and register writes, in plan order
  // --------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    if (!rst_ni) begin
      in_ch.valid  <= 1'b0;
      cfg_ch.valid <= 1'b0;
      in_busy     = 1'b0;
      cfg_busy    = 1'b0;
      in_lazy     = 1'b0;
      gap_left    = 0;
      settle      = 0;
      stim_done   = 1'b0;
      reg_limit   = 64'd1;
      reg_type_lo = '0;
      reg_type_hi = '0;
      reg_uniq_lo = '0;
      reg_uniq_hi = '0;
      reg_type_on = 1'b0;
      reg_uniq_on = 1'b0;
      tbl_sig_ok  = 1'b0;
      tbl_locked  = 1'b0;
      tbl_count   = 0;
      tbl_ovf     = 1'b0;
      tbl_idx     = '1;
      tbl_first   = '0;
      tbl_last    = '0;
    end else begin
      nx_in_vld  = in_ch.valid;
      nx_cfg_vld = cfg_ch.valid;

      // retire accepted requests into the predictor
      took_in = in_ch.valid && in_ch.ready;
      if (took_in) begin
        boot_choice_step(in_cur);
        nx_in_vld = 1'b0;
        in_busy   = 1'b0;
        // switch between bursts and gappy stretches now and then
        if ($urandom_range(0, 39) == 0) in_lazy = ~in_lazy;
        gap_left = in_lazy ? $urandom_range(0, 5) : 0;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        apply_reg(cfg_cur.reg_id, cfg_cur.reg_data);
        nx_cfg_vld = 1'b0;
        cfg_busy   = 1'b0;
        cfg_writes++;
      end

      // idle time: nothing in flight and no choice outstanding
      if (took_in || in_busy || pending_choices.size() != 0) begin
        settle = 0;
      end else if (settle < SettleCycles) begin
        settle++;
      end

      if (!in_busy && !cfg_busy && action_q.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          case (action_q[0].kind)
            ACT_REQ: begin
              in_cur = action_q.pop_front();
              in_ch.op              <= in_cur.op;
              in_ch.signature_word  <= in_cur.sig;
              in_ch.entry_first_lba <= in_cur.first_lba;
              in_ch.entry_last_lba  <= in_cur.last_lba;
              in_ch.entry_type_lo   <= in_cur.type_lo;
              in_ch.entry_type_hi   <= in_cur.type_hi;
              in_ch.entry_uniq_lo   <= in_cur.uniq_lo;
              in_ch.entry_uniq_hi   <= in_cur.uniq_hi;
              nx_in_vld = 1'b1;
              in_busy   = 1'b1;
            end
            ACT_CFG: begin
              // registers change only with the block idle
              if (settle >= SettleCycles) begin
                cfg_cur = action_q.pop_front();
                cfg_ch.index <= cfg_cur.reg_id;
                cfg_ch.data  <= cfg_cur.reg_data;
                nx_cfg_vld = 1'b1;
                cfg_busy   = 1'b1;
              end
            end
            default: begin
              if (settle >= SettleCycles) void'(action_q.pop_front());
            end
          endcase
        end
      end

      in_ch.valid  <= nx_in_vld;
      cfg_ch.valid <= nx_cfg_vld;
      stim_done = (action_q.size() == 0) && !in_busy && !cfg_busy;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: random back-pressure and field compare
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [LbaW-1:0] want,
                             input logic [LbaW-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_results
    boot_choice_t c;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      out_lazy = 1'b0;
      rdy_wait = 0;
    end else begin
      nx_rdy = out_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_choices.size() == 0) begin
          mismatches++;
          $display("%0t: result with no choice pending, expected none, got index %0d",
                   $time, out_ch.chosen_index);
        end else begin
          c = pending_choices.pop_front();
          check_field("chosen_index", 64'(c.idx), 64'(out_ch.chosen_index));
          check_field("chosen_first_lba", c.first_lba, out_ch.chosen_first_lba);
          check_field("chosen_last_lba", c.last_lba, out_ch.chosen_last_lba);
          check_field("table_valid", 64'(c.tbl_valid), 64'(out_ch.table_valid));
          check_field("index_overflow", 64'(c.ovf), 64'(out_ch.index_overflow));
          if (c.idx != -1) chosen_seen++;
          if (c.ovf) ovf_seen++;
        end
        if ($urandom_range(0, 29) == 0) out_lazy = ~out_lazy;
        rdy_wait = out_lazy ? $urandom_range(0, 5) : 0;
        nx_rdy   = (rdy_wait == 0);
      end else if (!out_ch.ready) begin
        if (rdy_wait > 0) rdy_wait--;
        nx_rdy = (rdy_wait == 0);
      end
      out_ch.ready <= nx_rdy;
    end
  end

  // --------------------------------------------------------------------------
  // end of run
  // --------------------------------------------------------------------------

  initial begin : finish_run
    mismatches   = 0;
    results_seen = 0;
    chosen_seen  = 0;
    ovf_seen     = 0;
    cfg_writes   = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    while (!stim_done) @(posedge clk_i);
    while (pending_choices.size() != 0) @(posedge clk_i);
    // catch any stray result behind the last one
    repeat (DrainCycles) @(posedge clk_i);
    $display("checked %0d choices from %0d requests (%0d tables), %0d register writes",
             results_seen, gen_req_count, gen_tables, cfg_writes);
    $display("choices with an entry picked: %0d, with overflow flagged: %0d",
             chosen_seen, ovf_seen);
    if (mismatches == 0) begin
      $display("PASS gpt_boot_partition_select_top");
    end else begin
      $display("FAIL gpt_boot_partition_select_top");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutTime);
    $display("%0t: timeout, %0d choices still pending", $time, pending_choices.size());
    $display("FAIL gpt_boot_partition_select_top");
    $finish;
  end

endmodule

[sim.f]
rtl/gbps_pkg.sv
rtl/gbps_if.sv
rtl/gpt_boot_partition_select_top.sv
rtl/gbps_checker.sv
bench/tb_gpt_boot_partition_select_top.sv
